/* rtl/hsfd_pkg.sv */
package hsfd_pkg;

   localparam logic [7:0]  CrcInit    = 8'hFF;
   localparam logic [7:0]  CrcPoly    = 8'h31;
   localparam logic [7:0]  CrcTop     = 8'h80;
   localparam logic [14:0] TempGain   = 15'd17500;
   localparam logic [14:0] HumGain    = 15'd10000;
   localparam logic [14:0] TempOffset = 15'd4500;
   localparam logic [30:0] RoundBias  = 31'd32767;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_BAD = 2'd1,
      STATUS_HUM_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } pos_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic signed [14:0] temp_centi;
      logic [13:0]        hum_centi;
   } result_type;

   // One byte through the CRC-8 register, MSB first.
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTop) != 8'd0) begin
            c = (c << 1) ^ CrcPoly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/hsfd_scale.sv */
module hsfd_scale (
   input  logic        sel_hum,
   input  logic [15:0] raw,
   output logic [14:0] centi
);
   import hsfd_pkg::*;

   logic [14:0] gain;
   logic [30:0] biased;
   logic [31:0] quot_sum;

   // The quotient by 65535 is (x + (x >> 16) + 1) >> 16, exact while it stays below 65536.
   always_comb begin
      gain     = sel_hum ? HumGain : TempGain;
      biased   = 31'(raw) * 31'(gain) + RoundBias;
      quot_sum = 32'(biased) + 32'(biased[30:16]) + 32'd1;
      centi    = quot_sum[30:16];
   end

endmodule

/* rtl/hsfd_frame.sv */
module hsfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   input  logic                frame_start,
   output logic                last_pending,
   output hsfd_pkg::result_type result
);
   import hsfd_pkg::*;

   pos_type            pos_ff, pos_in, pos;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         word_hi_ff, word_hi_in;
   logic [15:0]        temp_raw_ff, temp_raw_in;
   logic               temp_bad_ff, temp_bad_in;
   logic [15:0]        hum_raw_ff, hum_raw_in;
   logic signed [14:0] temp_centi_ff, temp_centi_in;
   logic               sel_hum;
   logic [15:0]        scale_raw;
   logic [14:0]        centi;
   logic               hum_bad;

   assign last_pending = (pos_ff == POS_HUM_CRC);

   // Each word is scaled on its CRC byte, when its raw value is already held.
   assign sel_hum   = (pos == POS_HUM_CRC);
   assign scale_raw = sel_hum ? hum_raw_ff : temp_raw_ff;

   hsfd_scale u_scale (
      .sel_hum (sel_hum),
      .raw     (scale_raw),
      .centi   (centi)
   );

   always_comb begin
      if (frame_start || (pos_ff > POS_HUM_CRC)) begin
         pos = POS_TEMP_HI;
      end else begin
         pos = pos_ff;
      end

      pos_in        = pos_ff;
      crc_in        = crc_ff;
      word_hi_in    = word_hi_ff;
      temp_raw_in   = temp_raw_ff;
      temp_bad_in   = temp_bad_ff;
      hum_raw_in    = hum_raw_ff;
      temp_centi_in = temp_centi_ff;
      hum_bad       = 1'b0;
      result        = '0;

      unique case (pos)
         POS_TEMP_HI: begin
            crc_in     = crc_feed(CrcInit, rx_byte);
            word_hi_in = rx_byte;
            pos_in     = POS_TEMP_LO;
         end
         POS_TEMP_LO: begin
            crc_in      = crc_feed(crc_ff, rx_byte);
            temp_raw_in = {word_hi_ff, rx_byte};
            pos_in      = POS_TEMP_CRC;
         end
         POS_TEMP_CRC: begin
            temp_bad_in   = (crc_ff != rx_byte);
            crc_in        = CrcInit;
            temp_centi_in = signed'(centi - TempOffset);
            pos_in        = POS_HUM_HI;
         end
         POS_HUM_HI: begin
            crc_in     = crc_feed(CrcInit, rx_byte);
            word_hi_in = rx_byte;
            pos_in     = POS_HUM_LO;
         end
         POS_HUM_LO: begin
            crc_in     = crc_feed(crc_ff, rx_byte);
            hum_raw_in = {word_hi_ff, rx_byte};
            pos_in     = POS_HUM_CRC;
         end
         POS_HUM_CRC: begin
            hum_bad      = (crc_ff != rx_byte);
            crc_in       = CrcInit;
            pos_in       = POS_TEMP_HI;
            result.valid = 1'b1;
            if (temp_bad_ff) begin
               result.status = STATUS_TEMP_BAD;
            end else if (hum_bad) begin
               result.status = STATUS_HUM_BAD;
            end else begin
               result.status     = STATUS_OK;
               result.temp_centi = temp_centi_ff;
               result.hum_centi  = centi[13:0];
            end
         end
         default: begin
            pos_in = POS_TEMP_HI;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_TEMP_HI;
         crc_ff <= CrcInit;
      end else if (accept) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_hi_ff    <= word_hi_in;
         temp_raw_ff   <= temp_raw_in;
         temp_bad_ff   <= temp_bad_in;
         hum_raw_ff    <= hum_raw_in;
         temp_centi_ff <= temp_centi_in;
      end
   end

endmodule

/* rtl/humidity_sensor_frame_decoder.sv */
// Channel   Direction  Ports                                   Carries
// req       in         req_valid/req_ready, req_rx_byte,       one frame byte
//                      req_frame_start
// rsp       out        rsp_valid/rsp_ready, rsp_status,        one decoded reading
//                      rsp_temp_centi, rsp_hum_centi
//
// One byte is taken every cycle unless held back as below; the result of a frame appears
// in the output register in the cycle after its sixth byte is taken.
// Reset returns the byte position to the first byte of a frame and empties the output.
// While a result waits in the output register, bytes keep being taken; only a byte offered
// in the sixth byte position of the next frame waits until the earlier result has left.
module humidity_sensor_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [14:0] rsp_temp_centi,
   output logic [13:0] rsp_hum_centi
);
   import hsfd_pkg::*;

   logic               accept;
   logic               last_pending;
   result_type         result;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic signed [14:0] rsp_temp_centi_ff;
   logic [13:0]        rsp_hum_centi_ff;

   assign req_ready = !(rsp_valid_ff && !rsp_ready && last_pending);
   assign accept    = req_valid && req_ready;

   hsfd_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .frame_start  (req_frame_start),
      .last_pending (last_pending),
      .result       (result)
   );

   always_comb begin
      if (accept && result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         rsp_status_ff     <= result.status;
         rsp_temp_centi_ff <= result.temp_centi;
         rsp_hum_centi_ff  <= result.hum_centi;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_temp_centi = rsp_temp_centi_ff;
   assign rsp_hum_centi  = rsp_hum_centi_ff;

endmodule

/* verif/frame_reading_checker.sv */
`timescale 1ns / 1ps

module frame_reading_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [14:0] rsp_temp_centi,
   input  logic [13:0]        rsp_hum_centi,
   output int                 fail_count,
   output int                 pending_count
);
   import hsfd_pkg::*;

   typedef struct {
      status_type         status;
      logic signed [14:0] temp_centi;
      logic [13:0]        hum_centi;
   } reading_type;

   reading_type expected_readings[$];
   pos_type     next_pos;
   logic [7:0]  crc_run;
   logic [7:0]  word_high;
   logic [15:0] temp_word;
   logic [15:0] hum_word;
   logic        temp_crc_bad;

   // Bit-serial form of the CRC-8 update, one data bit per shift.
   function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         if (r[7] ^ data[k]) begin
            r = {r[6:0], 1'b0} ^ CrcPoly;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic restart);
      pos_type     pos;
      reading_type r;
      logic        hum_crc_bad;
      longint      t;
      longint      h;
      pos = restart ? POS_TEMP_HI : next_pos;
      case (pos)
         POS_TEMP_HI, POS_HUM_HI: begin
            crc_run   = crc8_shift(CrcInit, b);
            word_high = b;
            next_pos  = (pos == POS_TEMP_HI) ? POS_TEMP_LO : POS_HUM_LO;
         end
         POS_TEMP_LO: begin
            crc_run   = crc8_shift(crc_run, b);
            temp_word = {word_high, b};
            next_pos  = POS_TEMP_CRC;
         end
         POS_TEMP_CRC: begin
            temp_crc_bad = (crc_run != b);
            crc_run      = CrcInit;
            next_pos     = POS_HUM_HI;
         end
         POS_HUM_LO: begin
            crc_run  = crc8_shift(crc_run, b);
            hum_word = {word_high, b};
            next_pos = POS_HUM_CRC;
         end
         POS_HUM_CRC: begin
            hum_crc_bad = (crc_run != b);
            crc_run     = CrcInit;
            next_pos    = POS_TEMP_HI;
            if (temp_crc_bad) begin
               r.status = STATUS_TEMP_BAD;
            end else if (hum_crc_bad) begin
               r.status = STATUS_HUM_BAD;
            end else begin
               r.status = STATUS_OK;
            end
            if (r.status == STATUS_OK) begin
               t = (longint'(TempGain) * longint'(temp_word) + longint'(RoundBias)) / 65535;
               h = (longint'(HumGain) * longint'(hum_word) + longint'(RoundBias)) / 65535;
               r.temp_centi = 15'(t - longint'(TempOffset));
               r.hum_centi  = 14'(h);
            end else begin
               r.temp_centi = '0;
               r.hum_centi  = '0;
            end
            expected_readings.push_back(r);
         end
         default: begin
            // A position past the last byte is taken as the first byte of a frame.
            crc_run   = crc8_shift(CrcInit, b);
            word_high = b;
            next_pos  = POS_TEMP_LO;
         end
      endcase
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         next_pos     = POS_TEMP_HI;
         crc_run      = CrcInit;
         word_high    = '0;
         temp_word    = '0;
         hum_word     = '0;
         temp_crc_bad = 1'b0;
         expected_readings.delete();
         fail_count   = 0;
      end else begin
         // Results are matched before the word of this edge is decoded, since a
         // reading never leaves on the edge that takes its last byte.
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected reading status %0d temp %0d hum %0d",
                           $realtime, rsp_status, rsp_temp_centi, rsp_hum_centi);
               end
            end else begin
               want = expected_readings.pop_front();
               if (rsp_status !== want.status || rsp_temp_centi !== want.temp_centi ||
                   rsp_hum_centi !== want.hum_centi) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: reading mismatch: status %0d/%0d temp %0d/%0d hum %0d/%0d",
                              $realtime, want.status, rsp_status, want.temp_centi,
                              rsp_temp_centi, want.hum_centi, rsp_hum_centi);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_byte(req_rx_byte, req_frame_start);
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

/* verif/humidity_sensor_frame_decoder_tb.sv */
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_tb;
   import hsfd_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [14:0] rsp_temp_centi;
   logic [13:0]        rsp_hum_centi;
   int                 fail_count;
   int                 pending_count;
   bit                 idle_on;
   bit                 hold_off_request;
   int                 bytes_sent;

   humidity_sensor_frame_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_temp_centi  (rsp_temp_centi),
      .rsp_hum_centi   (rsp_hum_centi)
   );

   frame_reading_checker reading_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_temp_centi  (rsp_temp_centi),
      .rsp_hum_centi   (rsp_hum_centi),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_off_request) begin
            rsp_ready        <= 1'b0;
            stall_left       = 79;
            hold_off_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_byte(input logic [7:0] b, input logic restart);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // A bad check byte is made by flipping a nonzero pattern into the good one.
   task automatic send_reading(input logic [15:0] t, input logic [15:0] h, input logic restart,
                               input bit temp_ok, input bit hum_ok);
      logic [7:0] t_crc;
      logic [7:0] h_crc;
      t_crc = crc_feed(crc_feed(CrcInit, t[15:8]), t[7:0]);
      h_crc = crc_feed(crc_feed(CrcInit, h[15:8]), h[7:0]);
      if (!temp_ok) t_crc ^= 8'($urandom_range(1, 255));
      if (!hum_ok) h_crc ^= 8'($urandom_range(1, 255));
      send_byte(t[15:8], restart);
      send_byte(t[7:0], 1'b0);
      send_byte(t_crc, 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h_crc, 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      bit hold_done;
      bit pause_done;
      bit resync;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      req_frame_start  = 1'b0;
      idle_on          = 1'b1;
      hold_off_request = 1'b0;
      bytes_sent       = 0;
      hold_done        = 1'b0;
      pause_done       = 1'b0;
      resync           = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_reading(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      send_reading(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1);
      // A lone first byte, dropped when the next frame restarts the count.
      send_byte(8'hA5, 1'b1);
      send_reading(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0);
      send_reading(16'h1234, 16'hFEDC, 1'b0, 1'b1, 1'b0);

      while (bytes_sent < 700) begin
         if (!hold_done && bytes_sent >= 200) begin
            hold_off_request = 1'b1;
            hold_done        = 1'b1;
         end
         if (!pause_done && bytes_sent >= 400) begin
            wait_drained();
            pause_done = 1'b1;
         end
         if (bytes_sent >= 600) idle_on = 1'b0;
         if ($urandom_range(0, 9) < 8) begin
            send_reading(16'($urandom), 16'($urandom), resync | 1'($urandom_range(0, 1)),
                         $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
            resync = 1'b0;
         end else begin
            // Broken frame: a few stray words with random restarts.
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            resync = 1'b1;
         end
      end
      wait_drained();

      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
